// File: rtl/core/soa_pkg.sv
// ----------------------------------------------------------------------------
// soa_pkg: shared types and constants for the sonar obstacle avoidance block
// Mode and command codes, field widths, timing constants and the structs
// that pass configuration, one tick and one step result between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package soa_pkg;

  localparam int MM_W    = 13;
  localparam int SPEED_W = 14;
  localparam int TIMER_W = 12;
  localparam int CODE_W  = 3;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [TIMER_W:0]   TICK_MS       = 13'd50;
  localparam logic [TIMER_W-1:0] TIMER_MAX     = 12'd4095;
  localparam logic [TIMER_W-1:0] STOP_HOLD_MS  = 12'd300;
  localparam logic [TIMER_W-1:0] TURN_LIMIT_MS = 12'd2000;
  localparam logic [TIMER_W-1:0] BACK_HOLD_MS  = 12'd800;
  // Room assumed for an absent side; it is above any 13-bit reading.
  localparam logic [MM_W:0]      SIDE_DEFAULT_MM = 14'd9990;

  // cruise*40/100 equals floor(2*cruise/5); the divide by five is a
  // multiply by ceil(2^18/5) and a shift, exact for any 15-bit dividend.
  localparam logic [15:0] SLOW_MUL   = 16'd52429;
  localparam int          SLOW_SHIFT = 18;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_STOP_MM       = 3'd0;
  localparam logic [2:0] REG_WARN_MM       = 3'd1;
  localparam logic [2:0] REG_SIDE_BLOCK_MM = 3'd2;
  localparam logic [2:0] REG_CRUISE_SPEED  = 3'd3;
  localparam logic [2:0] REG_TURN_SPEED    = 3'd4;
  localparam logic [2:0] REG_LEFT_FITTED   = 3'd5;
  localparam logic [2:0] REG_RIGHT_FITTED  = 3'd6;

  typedef enum logic [CODE_W-1:0] {
    MODE_FWD   = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_SCAN  = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_RIGHT = 3'd4,
    MODE_BACK  = 3'd5
  } mode_t;

  typedef enum logic [CODE_W-1:0] {
    CMD_NONE  = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_FWD   = 3'd2,
    CMD_LEFT  = 3'd3,
    CMD_RIGHT = 3'd4,
    CMD_BACK  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [MM_W-1:0]    stop_mm;
    logic [MM_W-1:0]    warn_mm;
    logic [MM_W-1:0]    side_block_mm;
    logic [SPEED_W-1:0] cruise_speed;
    logic [SPEED_W-1:0] turn_speed;
    logic               left_fitted;
    logic               right_fitted;
  } cfg_t;

  typedef struct packed {
    logic [MM_W-1:0] left_mm;
    logic            left_ok;
    logic [MM_W-1:0] front_mm;
    logic            front_ok;
    logic [MM_W-1:0] right_mm;
    logic            right_ok;
  } tick_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [SPEED_W-1:0] speed;
  } res_t;

  typedef struct packed {
    mode_t              mode_next;
    logic [TIMER_W-1:0] elapsed_next;
    logic               two;
    res_t               res0;
    res_t               res1;
  } step_t;

endpackage

`default_nettype wire

// File: rtl/core/soa_in_if.sv
// ----------------------------------------------------------------------------
// soa_in_if: tick channel
// Valid/ready channel that carries the three sonar readings of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface soa_in_if;
  logic                      valid;
  logic                      ready;
  logic [soa_pkg::MM_W-1:0]  left_mm;
  logic                      left_ok;
  logic [soa_pkg::MM_W-1:0]  front_mm;
  logic                      front_ok;
  logic [soa_pkg::MM_W-1:0]  right_mm;
  logic                      right_ok;

  modport source (output valid, left_mm, left_ok, front_mm, front_ok, right_mm, right_ok,
                  input ready);
  modport sink (input valid, left_mm, left_ok, front_mm, front_ok, right_mm, right_ok,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/soa_out_if.sv
// ----------------------------------------------------------------------------
// soa_out_if: motor command channel
// Valid/ready channel that carries one motor command result.
// ----------------------------------------------------------------------------
`default_nettype none

interface soa_out_if;
  logic                          valid;
  logic                          ready;
  logic [soa_pkg::CODE_W-1:0]    command;
  logic [soa_pkg::SPEED_W-1:0]   speed;
  logic [soa_pkg::CODE_W-1:0]    mode_now;
  logic                          last;

  modport source (output valid, command, speed, mode_now, last, input ready);
  modport sink (input valid, command, speed, mode_now, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sonar_obstacle_avoid_fsm.sv
// ----------------------------------------------------------------------------
// sonar_obstacle_avoid_fsm: ultrasonic obstacle avoidance state machine
// Path: an accepted tick passes the input register and then the result register.
// Throughput: one tick per cycle while the output takes every command; a tick
// with two commands holds the result register until both have been taken.
// Reset (rst, synchronous) sets forward mode, clears the timer, empties the
// pipeline and loads the default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module sonar_obstacle_avoid_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [soa_pkg::APB_AW-1:0]    paddr,
  input  logic [soa_pkg::APB_DW-1:0]    pwdata,
  output logic [soa_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  soa_in_if.sink                        in_item,
  soa_out_if.source                     out_item
);
  import soa_pkg::*;

  // Configuration registers. The user writes them only while the block is idle,
  // so the step logic reads them directly; the block does not enforce this.
  cfg_t               cfg;
  logic [2:0]         reg_idx;
  logic               cfg_write;

  // Input register: one tick waiting for the step logic.
  logic               tick_valid;
  tick_t              tick;

  // Architectural state of the avoidance machine.
  mode_t              mode;
  logic [TIMER_W-1:0] elapsed;

  // Result register: the one or two commands of the latest tick, sent in
  // order. phase selects the second command once the first is taken.
  logic               res_valid;
  logic               res_two;
  logic               phase;
  res_t               res0;
  res_t               res1;
  mode_t              res_mode;

  step_t              step;
  res_t               res_cur;
  logic               res_final;
  logic               res_free;
  logic               advance;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_AW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_STOP_MM:       prdata = APB_DW'(cfg.stop_mm);
      REG_WARN_MM:       prdata = APB_DW'(cfg.warn_mm);
      REG_SIDE_BLOCK_MM: prdata = APB_DW'(cfg.side_block_mm);
      REG_CRUISE_SPEED:  prdata = APB_DW'(cfg.cruise_speed);
      REG_TURN_SPEED:    prdata = APB_DW'(cfg.turn_speed);
      REG_LEFT_FITTED:   prdata = APB_DW'(cfg.left_fitted);
      REG_RIGHT_FITTED:  prdata = APB_DW'(cfg.right_fitted);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_mm       <= 13'd150;
      cfg.warn_mm       <= 13'd250;
      cfg.side_block_mm <= 13'd200;
      cfg.cruise_speed  <= 14'd3500;
      cfg.turn_speed    <= 14'd2500;
      cfg.left_fitted   <= 1'b1;
      cfg.right_fitted  <= 1'b1;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_STOP_MM:       cfg.stop_mm       <= pwdata[MM_W-1:0];
        REG_WARN_MM:       cfg.warn_mm       <= pwdata[MM_W-1:0];
        REG_SIDE_BLOCK_MM: cfg.side_block_mm <= pwdata[MM_W-1:0];
        REG_CRUISE_SPEED:  cfg.cruise_speed  <= pwdata[SPEED_W-1:0];
        REG_TURN_SPEED:    cfg.turn_speed    <= pwdata[SPEED_W-1:0];
        REG_LEFT_FITTED:   cfg.left_fitted   <= pwdata[0];
        REG_RIGHT_FITTED:  cfg.right_fitted  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  soa_step u_step (
    .cfg     (cfg),
    .tick    (tick),
    .mode    (mode),
    .elapsed (elapsed),
    .step    (step)
  );

  // The result register frees when its final command is taken; the queued
  // tick moves through the step logic in that same cycle, so single-command
  // ticks stream at full rate.
  assign res_final = !res_two || phase;
  assign res_free  = !res_valid || (out_item.ready && res_final);
  assign advance   = tick_valid && res_free;

  assign in_item.ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      res_valid  <= 1'b0;
      phase      <= 1'b0;
      mode       <= MODE_FWD;
      elapsed    <= '0;
    end else begin
      if (in_item.valid && in_item.ready) begin
        tick_valid     <= 1'b1;
        tick.left_mm   <= in_item.left_mm;
        tick.left_ok   <= in_item.left_ok;
        tick.front_mm  <= in_item.front_mm;
        tick.front_ok  <= in_item.front_ok;
        tick.right_mm  <= in_item.right_mm;
        tick.right_ok  <= in_item.right_ok;
      end else if (advance) begin
        tick_valid <= 1'b0;
      end

      if (advance) begin
        mode      <= step.mode_next;
        elapsed   <= step.elapsed_next;
        res_valid <= 1'b1;
        res_two   <= step.two;
        res0      <= step.res0;
        res1      <= step.res1;
        res_mode  <= step.mode_next;
        phase     <= 1'b0;
      end else if (res_valid && out_item.ready) begin
        if (res_final) begin
          res_valid <= 1'b0;
        end else begin
          phase <= 1'b1;
        end
      end
    end
  end

  assign res_cur           = phase ? res1 : res0;
  assign out_item.valid    = res_valid;
  assign out_item.command  = res_cur.cmd;
  assign out_item.speed    = res_cur.speed;
  assign out_item.mode_now = res_mode;
  assign out_item.last     = res_final;

endmodule

`default_nettype wire

// File: rtl/core/soa_step.sv
// ----------------------------------------------------------------------------
// soa_step: next-state and command logic for one tick
// From the current mode, timer, configuration and one tick of readings,
// works out the new mode and timer and the one or two motor commands.
// ----------------------------------------------------------------------------
`default_nettype none

module soa_step (
  input  soa_pkg::cfg_t                    cfg,
  input  soa_pkg::tick_t                   tick,
  input  soa_pkg::mode_t                   mode,
  input  logic [soa_pkg::TIMER_W-1:0]      elapsed,
  output soa_pkg::step_t                   step
);
  import soa_pkg::*;

  logic [TIMER_W:0]   elapsed_sum;
  logic [TIMER_W-1:0] elapsed_sat;
  logic               front_echo;
  logic               left_has;
  logic               right_has;
  logic               left_blk;
  logic               right_blk;
  logic [MM_W:0]      left_room;
  logic [MM_W:0]      right_room;
  mode_t              turn_pick;
  logic [30:0]        slow_prod;
  logic [SPEED_W-1:0] slow_speed;

  assign elapsed_sum = {1'b0, elapsed} + TICK_MS;
  assign elapsed_sat = (elapsed_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX
                                                         : elapsed_sum[TIMER_W-1:0];

  assign front_echo = tick.front_ok && (tick.front_mm != '0);

  // Side choice for a scan: a blocked side rules itself out and two blocked
  // sides mean backing up; otherwise the side with more room wins and a tie goes left.
  assign left_has   = cfg.left_fitted && tick.left_ok && (tick.left_mm != '0);
  assign right_has  = cfg.right_fitted && tick.right_ok && (tick.right_mm != '0);
  assign left_blk   = left_has && (tick.left_mm < cfg.side_block_mm);
  assign right_blk  = right_has && (tick.right_mm < cfg.side_block_mm);
  assign left_room  = left_has ? {1'b0, tick.left_mm} : SIDE_DEFAULT_MM;
  assign right_room = right_has ? {1'b0, tick.right_mm} : SIDE_DEFAULT_MM;

  always_comb begin
    priority if (left_blk && right_blk) begin
      turn_pick = MODE_BACK;
    end else if (left_blk) begin
      turn_pick = MODE_RIGHT;
    end else if (right_blk) begin
      turn_pick = MODE_LEFT;
    end else if (left_room >= right_room) begin
      turn_pick = MODE_LEFT;
    end else begin
      turn_pick = MODE_RIGHT;
    end
  end

  assign slow_prod  = 31'({cfg.cruise_speed, 1'b0}) * 31'(SLOW_MUL);
  assign slow_speed = SPEED_W'(slow_prod >> SLOW_SHIFT);

  always_comb begin
    step.mode_next    = mode;
    step.elapsed_next = elapsed_sat;
    step.two          = 1'b0;
    step.res0         = '{cmd: CMD_NONE, speed: '0};
    step.res1         = '{cmd: CMD_STOP, speed: '0};
    unique case (mode)
      MODE_STOP: begin
        if (elapsed_sat >= STOP_HOLD_MS) begin
          step.mode_next    = MODE_SCAN;
          step.elapsed_next = '0;
        end
      end
      MODE_SCAN: begin
        step.mode_next    = turn_pick;
        step.elapsed_next = '0;
      end
      MODE_LEFT, MODE_RIGHT: begin
        step.res0 = '{cmd: (mode == MODE_LEFT) ? CMD_LEFT : CMD_RIGHT,
                      speed: cfg.turn_speed};
        if (!tick.front_ok || (tick.front_mm > cfg.warn_mm)) begin
          step.mode_next    = MODE_FWD;
          step.elapsed_next = '0;
        end else if (elapsed_sat > TURN_LIMIT_MS) begin
          step.two          = 1'b1;
          step.mode_next    = MODE_SCAN;
          step.elapsed_next = '0;
        end
      end
      MODE_BACK: begin
        step.res0 = '{cmd: CMD_BACK, speed: cfg.turn_speed};
        if (elapsed_sat >= BACK_HOLD_MS) begin
          step.two          = 1'b1;
          step.mode_next    = MODE_SCAN;
          step.elapsed_next = '0;
        end
      end
      default: begin
        // Forward, and any code outside the six modes.
        if (front_echo && (tick.front_mm < cfg.stop_mm)) begin
          step.res0         = '{cmd: CMD_STOP, speed: '0};
          step.mode_next    = MODE_STOP;
          step.elapsed_next = '0;
        end else if (front_echo && (tick.front_mm < cfg.warn_mm)) begin
          step.res0 = '{cmd: CMD_FWD, speed: slow_speed};
        end else begin
          step.res0 = '{cmd: CMD_FWD, speed: cfg.cruise_speed};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// File: dv/sonar_obstacle_avoid_fsm_tb.sv
// ----------------------------------------------------------------------------
// sonar_obstacle_avoid_fsm_tb: self-checking bench for the obstacle avoider
// Sonar ticks go in over a valid/ready channel and configuration over APB.
// Motor commands are compared against a cycle-free behavioral predictor.
// Directed ticks come first, then randomized maneuvers under several
// settings, with output stalls and a long back-pressure hold.
// ----------------------------------------------------------------------------
`default_nettype none

module sonar_obstacle_avoid_fsm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import soa_pkg::*;

  // Timing and geometry of the avoidance behavior, kept local to the bench.
  localparam int TICK_STEP_MS   = 50;
  localparam int TIMER_CAP      = 4095;
  localparam int STOP_WAIT_MS   = 300;
  localparam int TURN_MAX_MS    = 2000;
  localparam int REVERSE_MS     = 800;
  localparam int SIDE_ABSENT_MM = 9990;
  localparam int MM_MAX         = 8191;
  localparam int SPEED_MAX      = 16383;

  // A tick passes the input and result registers before its first command
  // shows up, so a handful of quiet cycles is plenty before touching the registers.
  localparam int SETTLE_CYCLES   = 8;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT     = 200000;

  localparam cfg_t DEFAULT_SETTINGS = '{
    stop_mm: 13'd150, warn_mm: 13'd250, side_block_mm: 13'd200,
    cruise_speed: 14'd3500, turn_speed: 14'd2500,
    left_fitted: 1'b1, right_fitted: 1'b1
  };

  // One expected motor command, in the order the block must emit it.
  typedef struct packed {
    cmd_t               command;
    logic [SPEED_W-1:0] speed;
    mode_t              mode_now;
    logic               last;
  } motor_cmd_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  soa_in_if  tick_if ();
  soa_out_if res_if ();

  sonar_obstacle_avoid_fsm uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_item  (tick_if),
    .out_item (res_if)
  );

  // Predictor state: configuration, mode and the millisecond timer.
  cfg_t        pred_cfg = DEFAULT_SETTINGS;
  mode_t       pred_mode = MODE_FWD;
  logic [11:0] pred_elapsed = '0;

  motor_cmd_t cmd_expect_q[$];
  int         err_count = 0;
  int         cycle_count = 0;

  // Receiver behavior, chosen by the tests. The long hold is requested by
  // bumping hold_asked; the receiver counts the hold out on its own.
  int sink_style = 0;
  int hold_asked = 0;
  int hold_served = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run ends here as failed once cycle_count reaches CYCLE_LIMIT, which catches a block that stops making progress.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Behavioral predictor
  // --------------------------------------------------------------------------

  function automatic void enter_mode(input mode_t m);
    pred_mode = m;
    pred_elapsed = '0;
  endfunction

  // Side selection after a scan. A side with no sensor fitted or no echo is
  // never blocked and is treated as wide open; equal room goes left.
  function automatic mode_t choose_turn(input tick_t t);
    bit l_has, r_has, l_blk, r_blk;
    int l_room, r_room;
    l_has = pred_cfg.left_fitted && t.left_ok && (t.left_mm != 0);
    r_has = pred_cfg.right_fitted && t.right_ok && (t.right_mm != 0);
    l_blk = l_has && (t.left_mm < pred_cfg.side_block_mm);
    r_blk = r_has && (t.right_mm < pred_cfg.side_block_mm);
    if (l_blk && r_blk) return MODE_BACK;
    if (l_blk) return MODE_RIGHT;
    if (r_blk) return MODE_LEFT;
    l_room = l_has ? int'(t.left_mm) : SIDE_ABSENT_MM;
    r_room = r_has ? int'(t.right_mm) : SIDE_ABSENT_MM;
    return (l_room >= r_room) ? MODE_LEFT : MODE_RIGHT;
  endfunction

  // Advances the predicted state by one accepted tick and queues the one or
  // two motor commands that the tick must produce.
  function automatic void predict_tick(input tick_t t);
    cmd_t       cmds[2];
    int         speeds[2];
    int         n;
    int         timer;
    bit         front_echo;
    motor_cmd_t r;
    n = 0;
    front_echo = t.front_ok && (t.front_mm != 0);
    timer = int'(pred_elapsed) + TICK_STEP_MS;
    if (timer > TIMER_CAP) timer = TIMER_CAP;
    pred_elapsed = 12'(timer);

    case (pred_mode)
      MODE_STOP: begin
        if (pred_elapsed >= STOP_WAIT_MS) enter_mode(MODE_SCAN);
        cmds[n] = CMD_NONE;
        speeds[n] = 0;
        n++;
      end
      MODE_SCAN: begin
        enter_mode(choose_turn(t));
        cmds[n] = CMD_NONE;
        speeds[n] = 0;
        n++;
      end
      MODE_LEFT, MODE_RIGHT: begin
        cmds[n] = (pred_mode == MODE_LEFT) ? CMD_LEFT : CMD_RIGHT;
        speeds[n] = int'(pred_cfg.turn_speed);
        n++;
        // A valid zero reading is not clear, so the turn goes on.
        if (!t.front_ok || (t.front_mm > pred_cfg.warn_mm)) begin
          enter_mode(MODE_FWD);
        end else if (pred_elapsed > TURN_MAX_MS) begin
          cmds[n] = CMD_STOP;
          speeds[n] = 0;
          n++;
          enter_mode(MODE_SCAN);
        end
      end
      MODE_BACK: begin
        cmds[n] = CMD_BACK;
        speeds[n] = int'(pred_cfg.turn_speed);
        n++;
        if (pred_elapsed >= REVERSE_MS) begin
          cmds[n] = CMD_STOP;
          speeds[n] = 0;
          n++;
          enter_mode(MODE_SCAN);
        end
      end
      default: begin
        if (front_echo && (t.front_mm < pred_cfg.stop_mm)) begin
          cmds[n] = CMD_STOP;
          speeds[n] = 0;
          n++;
          enter_mode(MODE_STOP);
        end else if (front_echo && (t.front_mm < pred_cfg.warn_mm)) begin
          cmds[n] = CMD_FWD;
          speeds[n] = (int'(pred_cfg.cruise_speed) * 40) / 100;
          n++;
        end else begin
          cmds[n] = CMD_FWD;
          speeds[n] = int'(pred_cfg.cruise_speed);
          n++;
        end
      end
    endcase

    for (int k = 0; k < n; k++) begin
      r.command  = cmds[k];
      r.speed    = 14'(speeds[k]);
      r.mode_now = pred_mode;
      r.last     = (k == n - 1);
      cmd_expect_q.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------

  // Register value as the predictor holds it, for read-back checks.
  function automatic logic [31:0] reg_model(input logic [2:0] idx);
    case (idx)
      REG_STOP_MM:       return 32'(pred_cfg.stop_mm);
      REG_WARN_MM:       return 32'(pred_cfg.warn_mm);
      REG_SIDE_BLOCK_MM: return 32'(pred_cfg.side_block_mm);
      REG_CRUISE_SPEED:  return 32'(pred_cfg.cruise_speed);
      REG_TURN_SPEED:    return 32'(pred_cfg.turn_speed);
      REG_LEFT_FITTED:   return 32'(pred_cfg.left_fitted);
      REG_RIGHT_FITTED:  return 32'(pred_cfg.right_fitted);
      default:           return '0;
    endcase
  endfunction

  // One APB transfer: setup, then access until pready. The bus is parked
  // afterward so the next transfer starts from a clean setup.
  task automatic apb_access(input bit wr, input logic [2:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [31:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== reg_model(idx))
      note_failure($sformatf("register %0d read back %0d, expected %0d",
                             idx, got, reg_model(idx)));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    case (idx)
      REG_STOP_MM:       pred_cfg.stop_mm       = value[MM_W-1:0];
      REG_WARN_MM:       pred_cfg.warn_mm       = value[MM_W-1:0];
      REG_SIDE_BLOCK_MM: pred_cfg.side_block_mm = value[MM_W-1:0];
      REG_CRUISE_SPEED:  pred_cfg.cruise_speed  = value[SPEED_W-1:0];
      REG_TURN_SPEED:    pred_cfg.turn_speed    = value[SPEED_W-1:0];
      REG_LEFT_FITTED:   pred_cfg.left_fitted   = value[0];
      REG_RIGHT_FITTED:  pred_cfg.right_fitted  = value[0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(REG_STOP_MM,       32'(c.stop_mm));
    write_reg(REG_WARN_MM,       32'(c.warn_mm));
    write_reg(REG_SIDE_BLOCK_MM, 32'(c.side_block_mm));
    write_reg(REG_CRUISE_SPEED,  32'(c.cruise_speed));
    write_reg(REG_TURN_SPEED,    32'(c.turn_speed));
    write_reg(REG_LEFT_FITTED,   32'(c.left_fitted));
    write_reg(REG_RIGHT_FITTED,  32'(c.right_fitted));
  endtask

  // --------------------------------------------------------------------------
  // Tick source
  // --------------------------------------------------------------------------

  // Offers one tick and returns at the edge where it is taken. valid stays
  // high afterward so the caller can chain the next tick without a bubble.
  task automatic send_tick(input tick_t t);
    tick_if.valid    <= 1'b1;
    tick_if.left_mm  <= t.left_mm;
    tick_if.left_ok  <= t.left_ok;
    tick_if.front_mm <= t.front_mm;
    tick_if.front_ok <= t.front_ok;
    tick_if.right_mm <= t.right_mm;
    tick_if.right_ok <= t.right_ok;
    do @(posedge clk); while (!tick_if.ready);
    predict_tick(t);
  endtask

  // Drops valid, waits for every pending command, then lets the pipeline
  // go quiet so the registers can be written safely.
  task automatic settle();
    tick_if.valid <= 1'b0;
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic tick_t reading(input int l, input bit lok, input int f,
                                    input bit fok, input int r, input bit rok);
    tick_t t;
    t.left_mm  = 13'(l);
    t.left_ok  = lok;
    t.front_mm = 13'(f);
    t.front_ok = fok;
    t.right_mm = 13'(r);
    t.right_ok = rok;
    return t;
  endfunction

  function automatic logic [MM_W-1:0] clamp_mm(input int v);
    if (v < 0) return '0;
    if (v > MM_MAX) return 13'(MM_MAX);
    return 13'(v);
  endfunction

  // Side readings cluster around the blocking distance, with zeros, missing
  // echoes and full-range values mixed in.
  function automatic void side_reading(output logic [MM_W-1:0] mm, output logic ok);
    int blk;
    blk = int'(pred_cfg.side_block_mm);
    case ($urandom_range(0, 5))
      0:       mm = clamp_mm(blk - 1);
      1:       mm = clamp_mm(blk);
      2:       mm = clamp_mm(blk + int'($urandom_range(1, 400)));
      3:       mm = '0;
      default: mm = 13'($urandom_range(0, MM_MAX));
    endcase
    ok = ($urandom_range(0, 6) != 0);
  endfunction

  // Builds a tick suited to the predicted mode, so that most of the traffic
  // drives real maneuvers: forward ticks often cross the thresholds, and a
  // turn rarely sees a clear front so that timeouts and rescans happen.
  function automatic tick_t make_tick();
    tick_t t;
    int    stop_at, warn_at;
    stop_at = int'(pred_cfg.stop_mm);
    warn_at = int'(pred_cfg.warn_mm);
    side_reading(t.left_mm, t.left_ok);
    side_reading(t.right_mm, t.right_ok);
    if (pred_mode == MODE_SCAN && $urandom_range(0, 5) == 0) begin
      t.right_mm = t.left_mm;
      t.right_ok = t.left_ok;
    end
    t.front_ok = ($urandom_range(0, 7) != 0);
    case (pred_mode)
      MODE_LEFT, MODE_RIGHT: begin
        if ($urandom_range(0, 59) == 0) begin
          t.front_mm = 13'($urandom_range(0, MM_MAX));
          if (warn_at >= MM_MAX || $urandom_range(0, 1) == 0) t.front_ok = 1'b0;
          else t.front_mm = clamp_mm(warn_at + int'($urandom_range(1, 300)));
        end else begin
          t.front_ok = 1'b1;
          t.front_mm = 13'($urandom_range(0, warn_at));
        end
      end
      MODE_FWD: begin
        case ($urandom_range(0, 5))
          0:       t.front_mm = clamp_mm(stop_at - int'($urandom_range(1, 60)));
          1:       t.front_mm = clamp_mm(stop_at);
          2:       t.front_mm = clamp_mm(warn_at - int'($urandom_range(1, 60)));
          3:       t.front_mm = clamp_mm(warn_at);
          4:       t.front_mm = '0;
          default: t.front_mm = 13'($urandom_range(0, MM_MAX));
        endcase
      end
      default: t.front_mm = 13'($urandom_range(0, MM_MAX));
    endcase
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Command sink: stall patterns and the long hold
  // --------------------------------------------------------------------------

  initial begin : command_sink
    int run_left;
    bit run_level;
    run_left = 0;
    run_level = 1'b1;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        // Hold the output off long enough that the block backs up and
        // refuses new ticks while the source keeps offering them.
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
        hold_served++;
      end else begin
        case (sink_style)
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2: res_if.ready <= ($urandom_range(0, 9) < 3);
          3: begin
            if (run_left == 0) begin
              run_level = ~run_level;
              run_left = $urandom_range(1, 12);
            end
            run_left--;
            res_if.ready <= run_level;
          end
          default: res_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // Every command the block hands over is checked against the oldest
  // expectation; all four fields must match.
  always @(posedge clk) begin : command_check
    motor_cmd_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (cmd_expect_q.size() == 0) begin
        note_failure($sformatf("unexpected command: cmd=%0d speed=%0d mode=%0d last=%0b",
                               res_if.command, res_if.speed, res_if.mode_now, res_if.last));
      end else begin
        want = cmd_expect_q.pop_front();
        if ({res_if.command, res_if.speed, res_if.mode_now, res_if.last} !== want)
          note_failure($sformatf(
            "command mismatch: expected cmd=%0d speed=%0d mode=%0d last=%0b, got cmd=%0d speed=%0d mode=%0d last=%0b",
            want.command, want.speed, want.mode_now, want.last,
            res_if.command, res_if.speed, res_if.mode_now, res_if.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_register_defaults();
    check_reg(REG_STOP_MM);
    check_reg(REG_WARN_MM);
    check_reg(REG_SIDE_BLOCK_MM);
    check_reg(REG_CRUISE_SPEED);
    check_reg(REG_TURN_SPEED);
    check_reg(REG_LEFT_FITTED);
    check_reg(REG_RIGHT_FITTED);
  endtask

  // Forward driving at the default thresholds: open road, the warning band
  // and its edges, a valid zero reading, a missing echo and the far extreme.
  task automatic test_forward_speed_zones();
    sink_style = 0;
    send_tick(reading(1000, 1, 3000, 1, 1000, 1));
    send_tick(reading(1000, 1, 200, 1, 1000, 1));
    send_tick(reading(1000, 1, 150, 1, 1000, 1));
    send_tick(reading(1000, 1, 250, 1, 1000, 1));
    send_tick(reading(0, 0, 0, 1, 0, 0));
    send_tick(reading(MM_MAX, 1, 100, 0, MM_MAX, 1));
    send_tick(reading(MM_MAX, 1, MM_MAX, 1, MM_MAX, 1));
    settle();
  endtask

  // Two full avoidance cycles: stop, wait out the stop hold, scan, turn and
  // come back to forward. The first scan is a tie between two open sides,
  // and its turn sees an obstacle, the warning edge and a valid zero before
  // the front clears. The second scan has an echoless right side, which
  // counts as wide open, and the turn ends on a missing front echo.
  task automatic test_stop_scan_turn();
    sink_style = 1;
    send_tick(reading(500, 1, 149, 1, 500, 1));
    repeat (6) send_tick(reading(500, 1, 100, 1, 500, 1));
    send_tick(reading(MM_MAX, 1, 100, 1, MM_MAX, 1));
    send_tick(reading(500, 1, 100, 1, 500, 1));
    send_tick(reading(500, 1, 250, 1, 500, 1));
    send_tick(reading(500, 1, 0, 1, 500, 1));
    send_tick(reading(500, 1, 251, 1, 500, 1));
    send_tick(reading(500, 1, 1, 1, 500, 1));
    repeat (6) send_tick(reading(500, 1, 100, 1, 500, 1));
    send_tick(reading(300, 1, 100, 1, 5000, 0));
    send_tick(reading(300, 1, 100, 0, 5000, 1));
    settle();
  endtask

  // Randomized maneuvers under one setting. The source works in bursts with
  // random gaps, some of them zero, so gaps land in every mode.
  task automatic test_random_maneuvers(input cfg_t c, input int n_ticks, input int style);
    int burst_left;
    int gap;
    burst_left = 0;
    settle();
    load_settings(c);
    sink_style = style;
    for (int i = 0; i < n_ticks; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
          tick_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_tick(make_tick());
    end
    settle();
  endtask

  // The sink stops taking commands for a long stretch while ticks keep
  // coming back to back, so the block has to stall its input.
  task automatic test_output_backpressure();
    settle();
    load_settings(DEFAULT_SETTINGS);
    sink_style = 0;
    hold_asked++;
    repeat (40) send_tick(make_tick());
    settle();
  endtask

  initial begin : main
    cfg_t c;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    tick_if.valid    <= 1'b0;
    tick_if.left_mm  <= '0;
    tick_if.left_ok  <= 1'b0;
    tick_if.front_mm <= '0;
    tick_if.front_ok <= 1'b0;
    tick_if.right_mm <= '0;
    tick_if.right_ok <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_forward_speed_zones();
    test_stop_scan_turn();

    // Defaults, with a moderately stalling sink.
    test_random_maneuvers(DEFAULT_SETTINGS, 80, 1);

    // Low extremes: the robot never stops and almost every front echo is in the
    // warning band; top speeds; only the right sonar fitted.
    c = '{stop_mm: 13'd0, warn_mm: 13'(MM_MAX), side_block_mm: 13'd0,
          cruise_speed: 14'(SPEED_MAX), turn_speed: 14'(SPEED_MAX),
          left_fitted: 1'b0, right_fitted: 1'b1};
    test_random_maneuvers(c, 40, 0);

    // High extremes: almost any echo stops the robot, a fitted side is
    // almost always blocked and turns run into their timeout.
    c = '{stop_mm: 13'(MM_MAX), warn_mm: 13'(MM_MAX), side_block_mm: 13'(MM_MAX),
          cruise_speed: 14'd0, turn_speed: 14'd0,
          left_fitted: 1'b1, right_fitted: 1'b0};
    test_random_maneuvers(c, 80, 2);

    // No side sonar at all: every scan is a tie and turns left.
    c.stop_mm       = 13'($urandom_range(50, 600));
    c.warn_mm       = clamp_mm(int'(c.stop_mm) + int'($urandom_range(0, 400)));
    c.side_block_mm = 13'($urandom_range(0, 1000));
    c.cruise_speed  = 14'($urandom_range(0, SPEED_MAX));
    c.turn_speed    = 14'($urandom_range(0, SPEED_MAX));
    c.left_fitted   = 1'b0;
    c.right_fitted  = 1'b0;
    test_random_maneuvers(c, 60, 3);

    // Fully random setting, including a warning distance below the stop one.
    c.stop_mm       = 13'($urandom_range(0, MM_MAX));
    c.warn_mm       = 13'($urandom_range(0, MM_MAX));
    c.side_block_mm = 13'($urandom_range(0, MM_MAX));
    c.cruise_speed  = 14'($urandom_range(0, SPEED_MAX));
    c.turn_speed    = 14'($urandom_range(0, SPEED_MAX));
    c.left_fitted   = 1'($urandom_range(0, 1));
    c.right_fitted  = 1'($urandom_range(0, 1));
    test_random_maneuvers(c, 80, 1);

    test_output_backpressure();

    settle();
    if (err_count == 0 && cmd_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sonar_obstacle_avoid_fsm.f
rtl/core/soa_pkg.sv
rtl/core/soa_in_if.sv
rtl/core/soa_out_if.sv
rtl/core/soa_step.sv
rtl/core/sonar_obstacle_avoid_fsm.sv
dv/sonar_obstacle_avoid_fsm_tb.sv
